@@ hdl/rcpwm_pkg.sv @@
// Shared types and constants for the RC PWM pulse-width capture block.
// Used by rcpwm_chan_store, rcpwm_clamp and rc_pwm_pulse_width_capture.
// No dependencies.
package rcpwm_pkg;

  localparam int CH_W  = 4;
  localparam int TS_W  = 32;
  localparam int CFG_W = 16;
  localparam int OUT_W = 17;
  localparam int IDXR_W = 4;

  // Input commands.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [IDXR_W-1:0] REG_MIN_WIDTH      = 4'd0;
  localparam logic [IDXR_W-1:0] REG_MAX_WIDTH      = 4'd1;
  localparam logic [IDXR_W-1:0] REG_LOW_THRESHOLD  = 4'd2;
  localparam logic [IDXR_W-1:0] REG_HIGH_THRESHOLD = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] MIN_WIDTH_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] MAX_WIDTH_RST      = 16'd2000;
  localparam logic [CFG_W-1:0] LOW_THRESHOLD_RST  = 16'd1250;
  localparam logic [CFG_W-1:0] HIGH_THRESHOLD_RST = 16'd1750;

  // Band codes.
  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] min_width;
    logic [CFG_W-1:0] max_width;
    logic [CFG_W-1:0] low_threshold;
    logic [CFG_W-1:0] high_threshold;
  } cfg_t;

  // One pin event applied to the channel store.
  typedef struct packed {
    logic            en;
    logic            level;
    logic [TS_W-1:0] ts;
  } evt_t;

endpackage

@@ hdl/rc_pwm_pulse_width_capture.sv @@
// Top level of the RC PWM pulse-width capture block: input register,
// configuration registers and result register. Uses rcpwm_pkg,
// rcpwm_chan_store and rcpwm_clamp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, channel, pin_level and
//   timestamp_us. An edge item (command 0) updates the named channel and
//   yields no result. A read item (command 1) yields one result item on the
//   output channel (out_valid/out_ready): width_value, invalid and band.
//   Channels are numbered 1 to CHANNELS; others are ignored on edges and
//   reported as invalid on reads.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   is always ready and should be written only while the block is idle.
//   Throughput is one item per cycle. A read result passes through the input
//   register, where the channel store is updated or read, then through the
//   clamp and band logic into the result register.
//   When the receiver stalls, edge items keep flowing through; a read item
//   waits in the input register and in_ready drops only once both it and the
//   result register are held.
//   Reset clears all start times and widths and loads the default limits
//   1000/2000 and thresholds 1250/1750.
module rc_pwm_pulse_width_capture #(
  parameter int CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic [rcpwm_pkg::CH_W-1:0]           channel,
  input  logic                                 pin_level,
  input  logic [rcpwm_pkg::TS_W-1:0]           timestamp_us,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rcpwm_pkg::OUT_W-1:0]   width_value,
  output logic                                 invalid,
  output logic [1:0]                           band,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcpwm_pkg::IDXR_W-1:0]         cfg_index,
  input  logic [rcpwm_pkg::CFG_W-1:0]          cfg_data
);
  import rcpwm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_MAX = CH_W'(CHANNELS);

  cfg_t cfg;

  // Input register.
  logic            s1_valid;
  logic            s1_cmd;
  logic [CH_W-1:0] s1_ch;
  logic            s1_level;
  logic [TS_W-1:0] s1_ts;

  logic             ch_ok;
  logic [CH_W-1:0]  ch_m1;
  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             s1_adv;
  evt_t             evt;
  logic [TS_W-1:0]  rd_width;

  logic signed [OUT_W-1:0] width_value_next;
  logic [1:0]              band_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_width      <= MIN_WIDTH_RST;
      cfg.max_width      <= MAX_WIDTH_RST;
      cfg.low_threshold  <= LOW_THRESHOLD_RST;
      cfg.high_threshold <= HIGH_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_WIDTH:      cfg.min_width      <= cfg_data;
        REG_MAX_WIDTH:      cfg.max_width      <= cfg_data;
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data;
        REG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ch_ok = (s1_ch != '0) && (s1_ch <= CH_MAX);
  assign ch_m1 = s1_ch - CH_W'(1);
  assign idx   = ch_m1[IDX_W-1:0];

  // Edge items never produce a result, so they leave regardless of stalls.
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && ((s1_cmd == CMD_EDGE) || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd   <= command;
      s1_ch    <= channel;
      s1_level <= pin_level;
      s1_ts    <= timestamp_us;
    end
  end

  assign evt.en    = s1_valid && (s1_cmd == CMD_EDGE) && ch_ok;
  assign evt.level = s1_level;
  assign evt.ts    = s1_ts;

  rcpwm_chan_store #(
    .CHANNELS(CHANNELS),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .idx     (idx),
    .rd_width(rd_width)
  );

  rcpwm_clamp u_clamp (
    .cfg        (cfg),
    .width      (rd_width),
    .bad_ch     (!ch_ok),
    .width_value(width_value_next),
    .band       (band_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && (s1_cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && (s1_cmd == CMD_READ)) begin
      width_value <= width_value_next;
      invalid     <= !ch_ok;
      band        <= band_next;
    end
  end

  a_invalid_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> (width_value == '1) && (band == BAND_LOW))
    else $error("invalid result without -1 width and low band");

  a_valid_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalid |-> !width_value[OUT_W-1])
    else $error("negative width on a valid channel");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register is empty");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

@@ hdl/rcpwm_chan_store.sv @@
// Per-channel start time and pulse width registers with edge update.
// Depends on rcpwm_pkg.
module rcpwm_chan_store #(
  parameter int CHANNELS = 8,
  parameter int IDX_W    = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rcpwm_pkg::evt_t          evt,
  input  logic [IDX_W-1:0]         idx,
  output logic [rcpwm_pkg::TS_W-1:0] rd_width
);
  import rcpwm_pkg::*;

  logic [TS_W-1:0] start_time  [CHANNELS];
  logic [TS_W-1:0] pulse_width [CHANNELS];

  assign rd_width = pulse_width[idx];

  // A start time of zero means no rising edge is pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_time[i]  <= '0;
        pulse_width[i] <= '0;
      end
    end else if (evt.en) begin
      if (evt.level) begin
        start_time[idx] <= evt.ts;
      end else if (start_time[idx] != '0) begin
        pulse_width[idx] <= evt.ts - start_time[idx];
        start_time[idx]  <= '0;
      end
    end
  end

endmodule

@@ hdl/rcpwm_clamp.sv @@
// Clamps a stored pulse width to the configured limits and classifies it.
// Depends on rcpwm_pkg.
module rcpwm_clamp (
  input  rcpwm_pkg::cfg_t                  cfg,
  input  logic [rcpwm_pkg::TS_W-1:0]       width,
  input  logic                             bad_ch,
  output logic signed [rcpwm_pkg::OUT_W-1:0] width_value,
  output logic [1:0]                       band
);
  import rcpwm_pkg::*;

  logic signed [TS_W:0] w_s;
  logic signed [TS_W:0] min_s;
  logic signed [TS_W:0] max_s;
  logic [CFG_W-1:0]     clamped;

  // The stored width is two's complement, so long pulses read as negative.
  assign w_s   = {width[TS_W-1], width};
  assign min_s = $signed({{(TS_W+1-CFG_W){1'b0}}, cfg.min_width});
  assign max_s = $signed({{(TS_W+1-CFG_W){1'b0}}, cfg.max_width});

  always_comb begin
    if (w_s < min_s) begin
      clamped = cfg.min_width;
    end else if (w_s > max_s) begin
      clamped = cfg.max_width;
    end else begin
      // Here min <= w <= max, so the width fits in 16 bits.
      clamped = width[CFG_W-1:0];
    end

    if (bad_ch) begin
      width_value = '1;
      band        = BAND_LOW;
    end else begin
      width_value = $signed({1'b0, clamped});
      if (clamped >= cfg.high_threshold) begin
        band = BAND_HIGH;
      end else if (clamped >= cfg.low_threshold) begin
        band = BAND_MID;
      end else begin
        band = BAND_LOW;
      end
    end
  end

endmodule
